### rtl/quaternion_to_euler_degrees_defines.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_DEGREES_DEFINES_SVH
`define QUATERNION_TO_EULER_DEGREES_DEFINES_SVH

// same-cycle implication
`define Q2E_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("q2e assertion failed");

// next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("q2e assertion failed");

`endif

### rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: package
// Widths, latencies, angle constants, arctangent table and shared types.
// ----------------------------------------------------------------------------
package q2e_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_TAB_LEN = 24;
	localparam int CORDIC_N = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;

	localparam int QW = 16;       // quaternion component
	localparam int PW = 32;       // component product
	localparam int OPW = 36;      // arctangent operand
	localparam int CW = 45;       // CORDIC x/y datapath
	localparam int MW = 41;       // normalization magnitude
	localparam int AW = 27;       // angle, 1/65536 degree
	localparam int OW = 16;       // output angle
	localparam int RAD_W = 57;    // square root radicand
	localparam int RES_W = 58;    // square root work register
	localparam int ROOT_W = 29;   // square root result and pitch sine
	localparam int ISQ_STEPS = 29;

	localparam int PROD_LAT = 2;
	localparam int ISQ_LAT = ISQ_STEPS + 1;
	localparam int COR_LAT = CORDIC_N + 4;
	localparam int TOTAL_LAT = PROD_LAT + ISQ_LAT + COR_LAT;

	localparam logic signed [OPW-1:0] ONE_Q28 = 36'sd268435456;
	localparam logic signed [AW-1:0] DEG180 = 27'sd11796480;

	localparam logic [OW-1:0] ROLL_LO = 16'd0;
	localparam logic [OW-1:0] ROLL_HI = 16'd46080;
	localparam logic [OW-1:0] PITCH_LO = 16'd11520;
	localparam logic [OW-1:0] PITCH_HI = 16'd34560;

	typedef struct packed {
		logic signed [OPW-1:0] sr;
		logic signed [OPW-1:0] cr;
		logic signed [OPW-1:0] sy;
		logic signed [OPW-1:0] cy;
		logic signed [OPW-1:0] sp;
	} q2e_trig_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [MW-1:0] m;
	} q2e_vec_t;

	// atan(2^-i) in 1/65536 degree, rounded to nearest
	function automatic logic signed [AW-1:0] atan_tab(input int idx);
		logic signed [AW-1:0] v;
		case (idx)
			0: v = 27'sd2949120;
			1: v = 27'sd1740967;
			2: v = 27'sd919879;
			3: v = 27'sd466945;
			4: v = 27'sd234379;
			5: v = 27'sd117304;
			6: v = 27'sd58666;
			7: v = 27'sd29335;
			8: v = 27'sd14668;
			9: v = 27'sd7334;
			10: v = 27'sd3667;
			11: v = 27'sd1833;
			12: v = 27'sd917;
			13: v = 27'sd458;
			14: v = 27'sd229;
			15: v = 27'sd115;
			16: v = 27'sd57;
			17: v = 27'sd29;
			18: v = 27'sd14;
			19: v = 27'sd7;
			20: v = 27'sd4;
			21: v = 27'sd2;
			22: v = 27'sd1;
			default: v = 27'sd0;
		endcase
		return v;
	endfunction
endpackage

### rtl/quaternion_to_euler_degrees.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles (z-y-x order), degrees
// Takes one quaternion (w, x, y, z) in signed Q1.14 per item and returns roll,
// pitch and yaw in 1/128 degree, each offset by +180 degrees so it lies in
// 0..46080. The block is a fixed pipeline: it takes one item every clock while
// the pipe is not stalled, and passes it through 2 product stages, the pitch
// cosine square root, one bit per stage, then the vectoring CORDIC. Roll and
// yaw wait in a delay line while the square root runs. When |2(wy - zx)| reaches
// one, pitch is pinned to +-90 degrees and has_gimbal_lock is set. All stages
// advance together; a stall on out_ready freezes the whole pipe, and in_ready
// is high whenever the output register is empty or being drained.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_degrees_defines.svh"

module quaternion_to_euler_degrees import q2e_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [QW-1:0] quat_w,
	input logic signed [QW-1:0] quat_x,
	input logic signed [QW-1:0] quat_y,
	input logic signed [QW-1:0] quat_z,
	output logic out_valid,
	input logic out_ready,
	output logic [OW-1:0] roll_angle,
	output logic [OW-1:0] pitch_angle,
	output logic [OW-1:0] yaw_angle,
	output logic has_gimbal_lock
);
	logic en;
	logic valid_s [TOTAL_LAT];

	q2e_trig_t trig;
	q2e_trig_t dly_s [ISQ_LAT];

	logic [ROOT_W-1:0] root;
	logic signed [OPW-1:0] sine;
	logic lock, pole_pos;
	logic lk_s [COR_LAT];
	logic pp_s [COR_LAT];

	logic [OW-1:0] roll_raw, pitch_raw, yaw_raw;

	// advance the whole pipe unless a finished item is held at the output
	assign en = out_ready || !valid_s[TOTAL_LAT-1];
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TOTAL_LAT; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int k = 1; k < TOTAL_LAT; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	q2e_prod u_prod (
		.clk (clk),
		.en (en),
		.qw (quat_w),
		.qx (quat_x),
		.qy (quat_y),
		.qz (quat_z),
		.trig (trig)
	);

	// pitch cosine; roll and yaw terms wait alongside
	q2e_psqrt u_psqrt (
		.clk (clk),
		.en (en),
		.sp (trig.sp),
		.root (root),
		.sine (sine),
		.lock (lock),
		.pole_pos (pole_pos)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dly_s[0] <= trig;
			for (int k = 1; k < ISQ_LAT; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	q2e_cordic u_roll (
		.clk (clk),
		.en (en),
		.y_in (dly_s[ISQ_LAT-1].sr),
		.x_in (dly_s[ISQ_LAT-1].cr),
		.lo (ROLL_LO),
		.hi (ROLL_HI),
		.angle (roll_raw)
	);

	q2e_cordic u_pitch (
		.clk (clk),
		.en (en),
		.y_in (sine),
		.x_in (OPW'(root)),
		.lo (PITCH_LO),
		.hi (PITCH_HI),
		.angle (pitch_raw)
	);

	q2e_cordic u_yaw (
		.clk (clk),
		.en (en),
		.y_in (dly_s[ISQ_LAT-1].sy),
		.x_in (dly_s[ISQ_LAT-1].cy),
		.lo (ROLL_LO),
		.hi (ROLL_HI),
		.angle (yaw_raw)
	);

	// carry the pole flag and its sign past the CORDIC
	always_ff @(posedge clk) begin
		if (en) begin
			lk_s[0] <= lock;
			pp_s[0] <= pole_pos;
			for (int k = 1; k < COR_LAT; k++) begin
				lk_s[k] <= lk_s[k-1];
				pp_s[k] <= pp_s[k-1];
			end
		end
	end

	assign out_valid = valid_s[TOTAL_LAT-1];
	assign roll_angle = roll_raw;
	assign yaw_angle = yaw_raw;
	assign has_gimbal_lock = lk_s[COR_LAT-1];
	// pin pitch to +-90 degrees at a pole
	assign pitch_angle = lk_s[COR_LAT-1] ? (pp_s[COR_LAT-1] ? PITCH_HI : PITCH_LO) : pitch_raw;

	`Q2E_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_s[0])
	`Q2E_ASSERT_IMPL(a_pole_pinned, out_valid && has_gimbal_lock, pitch_angle == PITCH_LO || pitch_angle == PITCH_HI)
	`Q2E_ASSERT_IMPL(a_pitch_range, out_valid, pitch_angle >= PITCH_LO && pitch_angle <= PITCH_HI)
	`Q2E_ASSERT_IMPL(a_roll_yaw_range, out_valid, roll_angle <= ROLL_HI && yaw_angle <= ROLL_HI)
endmodule

### rtl/q2e_prod.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: product stages
// Component products, then the sine and cosine terms of the three angles.
// ----------------------------------------------------------------------------
module q2e_prod import q2e_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [QW-1:0] qw,
	input logic signed [QW-1:0] qx,
	input logic signed [QW-1:0] qy,
	input logic signed [QW-1:0] qz,
	output q2e_trig_t trig
);
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	q2e_trig_t trig_s2;

	function automatic logic signed [OPW-1:0] dbl_sum(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b);
		logic signed [OPW-1:0] s;
		s = OPW'(a) + OPW'(b);
		return s <<< 1;
	endfunction

	function automatic logic signed [OPW-1:0] dbl_diff(input logic signed [PW-1:0] a,
			input logic signed [PW-1:0] b);
		logic signed [OPW-1:0] s;
		s = OPW'(a) - OPW'(b);
		return s <<< 1;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= qw * qx;
			yz_s1 <= qy * qz;
			xx_s1 <= qx * qx;
			yy_s1 <= qy * qy;
			wz_s1 <= qw * qz;
			xy_s1 <= qx * qy;
			zz_s1 <= qz * qz;
			wy_s1 <= qw * qy;
			zx_s1 <= qz * qx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s2.sr <= dbl_sum(wx_s1, yz_s1);
			trig_s2.cr <= ONE_Q28 - dbl_sum(xx_s1, yy_s1);
			trig_s2.sy <= dbl_sum(wz_s1, xy_s1);
			trig_s2.cy <= ONE_Q28 - dbl_sum(yy_s1, zz_s1);
			trig_s2.sp <= dbl_diff(wy_s1, zx_s1);
		end
	end

	assign trig = trig_s2;
endmodule

### rtl/q2e_psqrt.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: pitch cosine
// Pole check, then sqrt(1 - s^2) one result bit per stage.
// ----------------------------------------------------------------------------
module q2e_psqrt import q2e_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [OPW-1:0] sp,
	output logic [ROOT_W-1:0] root,
	output logic signed [OPW-1:0] sine,
	output logic lock,
	output logic pole_pos
);
	localparam logic [RAD_W-1:0] RAD_ONE = {1'b1, {(RAD_W-1){1'b0}}};

	logic signed [ROOT_W-1:0] sp_t;
	logic signed [2*ROOT_W-1:0] sq;
	logic lock_c;

	logic [RAD_W-1:0] n_s [ISQ_STEPS+1];
	logic [RES_W-1:0] r_s [ISQ_STEPS+1];
	logic signed [ROOT_W-1:0] sin_s [ISQ_STEPS+1];
	logic lock_s [ISQ_STEPS+1];
	logic pos_s [ISQ_STEPS+1];

	always_comb begin
		sp_t = $signed(sp[ROOT_W-1:0]);
		sq = sp_t * sp_t;
		lock_c = (sp >= ONE_Q28) || (sp <= -ONE_Q28);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= RAD_ONE - sq[RAD_W-1:0];
			r_s[0] <= '0;
			sin_s[0] <= sp_t;
			lock_s[0] <= lock_c;
			pos_s[0] <= !sp[OPW-1];
		end
	end

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
		localparam logic [RES_W-1:0] BITV = RES_W'(1) << (2 * (ISQ_STEPS - 1 - k));
		logic [RES_W-1:0] trial;
		logic fits;

		assign trial = r_s[k] + BITV;
		assign fits = {1'b0, n_s[k]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1] <= fits ? n_s[k] - trial[RAD_W-1:0] : n_s[k];
				r_s[k+1] <= fits ? (r_s[k] >> 1) + BITV : r_s[k] >> 1;
				sin_s[k+1] <= sin_s[k];
				lock_s[k+1] <= lock_s[k];
				pos_s[k+1] <= pos_s[k];
			end
		end
	end

	assign root = r_s[ISQ_STEPS][ROOT_W-1:0];
	assign sine = OPW'(sin_s[ISQ_STEPS]);
	assign lock = lock_s[ISQ_STEPS];
	assign pole_pos = pos_s[ISQ_STEPS];
endmodule

### rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: vectoring CORDIC
// Half-plane fold, normalize, CORDIC_N stages, round to 1/128 degree, clamp.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; (
	input logic clk,
	input logic en,
	input logic signed [OPW-1:0] y_in,
	input logic signed [OPW-1:0] x_in,
	input logic [OW-1:0] lo,
	input logic [OW-1:0] hi,
	output logic [OW-1:0] angle
);
	logic neg;
	logic signed [OPW-1:0] xa, ya, ym;
	logic [MW-1:0] m_c;

	q2e_vec_t v_s1, v_s2, v_s3;
	logic signed [AW-1:0] a_s1, a_s2, a_s3;
	logic zero_s1, zero_s2, zero_s3;

	logic signed [CW-1:0] x_c [CORDIC_N+1];
	logic signed [CW-1:0] y_c [CORDIC_N+1];
	logic signed [AW-1:0] a_c [CORDIC_N+1];
	logic zero_c [CORDIC_N+1];

	logic signed [AW-1:0] a_use;
	logic signed [AW:0] rnd;
	logic signed [AW-9:0] qv, off, lo_x, hi_x, clamped;
	logic [OW-1:0] angle_sout;

	function automatic q2e_vec_t norm3(input q2e_vec_t v, input int base);
		q2e_vec_t r;
		int s;
		r = v;
		for (int j = 0; j < 3; j++) begin
			s = base >> j;
			if ((r.m >> (MW - s)) == '0) begin
				r.m = r.m << s;
				r.x = r.x <<< s;
				r.y = r.y <<< s;
			end
		end
		return r;
	endfunction

	// fold x < 0 into the right half-plane
	always_comb begin
		neg = x_in[OPW-1];
		xa = neg ? -x_in : x_in;
		ya = neg ? -y_in : y_in;
		ym = ya[OPW-1] ? -ya : ya;
		m_c = (xa > ym) ? MW'(xa) : MW'(ym);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1.x <= CW'(xa);
			v_s1.y <= CW'(ya);
			v_s1.m <= m_c;
			a_s1 <= neg ? (y_in[OPW-1] ? -DEG180 : DEG180) : '0;
			zero_s1 <= (x_in == '0) && (y_in == '0);
			v_s2 <= norm3(v_s1, 32);
			a_s2 <= a_s1;
			zero_s2 <= zero_s1;
			v_s3 <= norm3(v_s2, 4);
			a_s3 <= a_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign x_c[0] = v_s3.x;
	assign y_c[0] = v_s3.y;
	assign a_c[0] = a_s3;
	assign zero_c[0] = zero_s3;

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
		logic signed [CW-1:0] dx, dy;
		assign dx = y_c[i] >>> i;
		assign dy = x_c[i] >>> i;

		// rotate toward y = 0
		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_c[i][CW-1]) begin
					x_c[i+1] <= x_c[i] + dx;
					y_c[i+1] <= y_c[i] - dy;
					a_c[i+1] <= a_c[i] + atan_tab(i);
				end else begin
					x_c[i+1] <= x_c[i] - dx;
					y_c[i+1] <= y_c[i] + dy;
					a_c[i+1] <= a_c[i] - atan_tab(i);
				end
				zero_c[i+1] <= zero_c[i];
			end
		end
	end

	// round to 1/128 degree, offset by 180 degrees, clamp
	always_comb begin
		a_use = zero_c[CORDIC_N] ? '0 : a_c[CORDIC_N];
		rnd = (AW+1)'(a_use) + 28'sd256;
		qv = $signed(rnd[AW:9]);
		off = qv + 19'sd23040;
		lo_x = $signed({3'b000, lo});
		hi_x = $signed({3'b000, hi});
		if (off < lo_x) begin
			clamped = lo_x;
		end else if (off > hi_x) begin
			clamped = hi_x;
		end else begin
			clamped = off;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_sout <= clamped[OW-1:0];
		end
	end

	assign angle = angle_sout;
endmodule
